// ----- rtl/idle_stop_supervisor_core_assert.svh -----
// ----------------------------------------------------------------------------
// idle stop supervisor assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef IDLE_STOP_SUPERVISOR_CORE_ASSERT_SVH
`define IDLE_STOP_SUPERVISOR_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define ISS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define ISS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, always checked
`define ISS_ASSERT_NXT_ANY(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/iss_pkg.sv -----
// ----------------------------------------------------------------------------
// iss_pkg
// types, codes and reset values of the idle stop supervisor
// ----------------------------------------------------------------------------
package iss_pkg;

   localparam int unsigned TIMEOUT_W = 24;
   localparam int unsigned WARN_W    = 16;
   localparam int unsigned HOLD_W    = 16;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned CSR_W     = 24;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 16;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 24'd60000;
   localparam logic [WARN_W-1:0]    WARN_RST    = 16'd5000;
   localparam logic [HOLD_W-1:0]    HOLD_RST    = 16'd800;

   // register index codes
   localparam logic [CSR_ADDR_W-1:0] CSR_IDLE_TIMEOUT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WARN_WINDOW  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELAY_HOLD   = 2'd2;

   // link health codes
   localparam logic [1:0] LINK_OK        = 2'd0;
   localparam logic [1:0] LINK_CAN_ERROR = 2'd1;
   localparam logic [1:0] LINK_CAN_TMO   = 2'd2;
   localparam logic [1:0] LINK_OTHER     = 2'd3;

   // machine condition codes
   localparam logic [1:0] COND_UNKNOWN = 2'd0;
   localparam logic [1:0] COND_IDLE    = 2'd1;
   localparam logic [1:0] COND_WORKING = 2'd2;

   // reported state codes
   localparam logic [2:0] CODE_MONITOR = 3'd0;
   localparam logic [2:0] CODE_IDLE    = 3'd1;
   localparam logic [2:0] CODE_COUNT   = 3'd2;
   localparam logic [2:0] CODE_REQ     = 3'd3;
   localparam logic [2:0] CODE_ACTIVE  = 3'd4;
   localparam logic [2:0] CODE_FAULT   = 3'd5;

   // output latch masks
   localparam logic [5:0] L_RELAY  = 6'b000001;
   localparam logic [5:0] L_YELLOW = 6'b000010;
   localparam logic [5:0] L_RED    = 6'b000100;
   localparam logic [5:0] L_GREEN  = 6'b001000;
   localparam logic [5:0] L_PINA   = 6'b010000;
   localparam logic [5:0] L_PINB   = 6'b100000;

   typedef enum logic [5:0] {
      ST_MONITOR = 6'b000001,
      ST_IDLE    = 6'b000010,
      ST_COUNT   = 6'b000100,
      ST_REQ     = 6'b001000,
      ST_ACTIVE  = 6'b010000,
      ST_FAULT   = 6'b100000
   } state_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] idle_timeout_ms;
      logic [WARN_W-1:0]    warn_window_ms;
      logic [HOLD_W-1:0]    relay_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic              work_done;
      logic [1:0]        machine_condition;
      logic [1:0]        link_health;
      logic [TIME_W-1:0] now_ms;
   } item_type;

   typedef struct packed {
      state_type         st;
      logic              cd_active;
      logic [TIME_W-1:0] cd_start;
      logic [TIME_W-1:0] relay_on;
      logic [5:0]        latches;
   } ctx_type;

   typedef struct packed {
      logic       idle_stop_event;
      logic [5:0] latches;
      logic [2:0] state_code;
   } result_type;

   function automatic logic [2:0] state_code_of(input state_type st);
      logic [2:0] code;
      unique case (st)
         ST_MONITOR: code = CODE_MONITOR;
         ST_IDLE:    code = CODE_IDLE;
         ST_COUNT:   code = CODE_COUNT;
         ST_REQ:     code = CODE_REQ;
         ST_ACTIVE:  code = CODE_ACTIVE;
         ST_FAULT:   code = CODE_FAULT;
         default:    code = CODE_FAULT;
      endcase
      return code;
   endfunction

endpackage

// ----- rtl/idle_stop_supervisor_core.sv -----
// ----------------------------------------------------------------------------
// idle_stop_supervisor_core
// idle stop supervisor: one supervision tick in, one status result out
// ----------------------------------------------------------------------------
// channel  dir  handshake               payload
// req      in   req_tvalid/req_tready   tick: time, link, condition, work flag
// rsp      out  rsp_tvalid/rsp_tready   state code, latches, stop event
// csr      in   csr_we                  idle timeout, warn window, relay hold
//
// one transaction per cycle sustained while rsp_tready keeps results moving; from req to rsp:
// input register, single-pass update logic, result register
// reset (synchronous) clears state and loads register defaults
// a stalled rsp holds its result; req stays open while the input stage can move
// ----------------------------------------------------------------------------
module idle_stop_supervisor_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // now_ms[31:0], link_health[33:32], machine_condition[35:34], work_done[36]
   input  logic [iss_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // state_code[2:0], cutoff_relay[3], lamp_yellow[4], lamp_red[5],
   // lamp_green[6], aux_pin_a[7], aux_pin_b[8], idle_stop_event[9]
   output logic [iss_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [iss_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [iss_pkg::CSR_W-1:0]         csr_wdata
);

   iss_pkg::cfg_type    cfg_ff;
   iss_pkg::ctx_type    ctx_ff;
   iss_pkg::ctx_type    ctx_in;
   iss_pkg::item_type   item_ff;
   iss_pkg::result_type res_in;
   iss_pkg::result_type res_ff;
   logic                in_valid_ff;
   logic                out_valid_ff;
   logic                advance;
   logic                take;

   assign advance    = !out_valid_ff || rsp_tready;
   assign take       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, res_ff.idle_stop_event, res_ff.latches, res_ff.state_code};

   iss_step u_step (
      .cfg    (cfg_ff),
      .ctx    (ctx_ff),
      .item   (item_ff),
      .ctx_in (ctx_in),
      .res    (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_timeout_ms <= iss_pkg::TIMEOUT_RST;
         cfg_ff.warn_window_ms  <= iss_pkg::WARN_RST;
         cfg_ff.relay_hold_ms   <= iss_pkg::HOLD_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            iss_pkg::CSR_IDLE_TIMEOUT: cfg_ff.idle_timeout_ms <= csr_wdata;
            iss_pkg::CSR_WARN_WINDOW:  cfg_ff.warn_window_ms  <= csr_wdata[iss_pkg::WARN_W-1:0];
            iss_pkg::CSR_RELAY_HOLD:   cfg_ff.relay_hold_ms   <= csr_wdata[iss_pkg::HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         ctx_ff.st         <= iss_pkg::ST_MONITOR;
         ctx_ff.cd_active  <= 1'b0;
         ctx_ff.cd_start   <= '0;
         ctx_ff.relay_on   <= '0;
         ctx_ff.latches    <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (take) begin
            ctx_ff <= ctx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_tdata[$bits(iss_pkg::item_type)-1:0];
      end
      if (take) begin
         res_ff <= res_in;
      end
   end

endmodule

// ----- rtl/iss_step.sv -----
// ----------------------------------------------------------------------------
// iss_step
// next state, output latches and event for one supervision tick
// ----------------------------------------------------------------------------
module iss_step (
   input  iss_pkg::cfg_type    cfg,
   input  iss_pkg::ctx_type    ctx,
   input  iss_pkg::item_type   item,
   output iss_pkg::ctx_type    ctx_in,
   output iss_pkg::result_type res
);

   logic [iss_pkg::TIME_W-1:0]    elapsed;
   logic                          over;
   logic [iss_pkg::TIMEOUT_W-1:0] remaining;
   logic                          warn_hit;
   logic                          expired;
   logic [iss_pkg::TIME_W-1:0]    on_time;
   logic                          hold_done;
   logic                          link_fault;
   logic [5:0]                    lat;
   logic                          event_hit;

   assign elapsed   = ctx.cd_active ? (item.now_ms - ctx.cd_start) : '0;
   assign over      = elapsed >= {8'b0, cfg.idle_timeout_ms};
   assign remaining = over ? '0 : (cfg.idle_timeout_ms - elapsed[iss_pkg::TIMEOUT_W-1:0]);
   assign warn_hit  = remaining <= {8'b0, cfg.warn_window_ms};
   assign expired   = ctx.cd_active && over;
   assign on_time   = item.now_ms - ctx.relay_on;
   assign hold_done = on_time >= {16'b0, cfg.relay_hold_ms};
   assign link_fault = (item.link_health == iss_pkg::LINK_CAN_ERROR) ||
                       (item.link_health == iss_pkg::LINK_CAN_TMO);

   always_comb begin
      ctx_in    = ctx;
      lat       = ctx.latches;
      event_hit = 1'b0;
      if (link_fault) begin
         ctx_in.cd_active = 1'b0;
         ctx_in.st        = iss_pkg::ST_FAULT;
         lat = (lat | iss_pkg::L_YELLOW) & ~iss_pkg::L_GREEN;
      end else begin
         unique case (ctx.st)
            iss_pkg::ST_MONITOR: begin
               if (item.machine_condition == iss_pkg::COND_WORKING) begin
                  ctx_in.cd_active = 1'b0;
                  lat = lat | iss_pkg::L_PINA | iss_pkg::L_PINB | iss_pkg::L_GREEN;
                  lat = lat & ~(iss_pkg::L_RELAY | iss_pkg::L_YELLOW | iss_pkg::L_RED);
               end else if (item.machine_condition == iss_pkg::COND_IDLE &&
                            item.work_done) begin
                  ctx_in.st = iss_pkg::ST_IDLE;
               end
            end
            iss_pkg::ST_IDLE: begin
               ctx_in.cd_active = 1'b1;
               ctx_in.cd_start  = item.now_ms;
               ctx_in.st        = iss_pkg::ST_COUNT;
               lat = lat & ~(iss_pkg::L_RELAY | iss_pkg::L_GREEN | iss_pkg::L_PINA);
               lat = lat | iss_pkg::L_PINB;
            end
            iss_pkg::ST_COUNT: begin
               if (warn_hit) begin
                  lat = lat | iss_pkg::L_RED | iss_pkg::L_PINA;
                  lat = lat & ~(iss_pkg::L_YELLOW | iss_pkg::L_GREEN);
               end else begin
                  lat = (lat & ~iss_pkg::L_RED) | iss_pkg::L_PINB;
               end
               if (item.machine_condition == iss_pkg::COND_WORKING) begin
                  ctx_in.cd_active = 1'b0;
                  ctx_in.st        = iss_pkg::ST_MONITOR;
                  lat = lat & ~(iss_pkg::L_RELAY | iss_pkg::L_YELLOW |
                                iss_pkg::L_RED | iss_pkg::L_GREEN);
               end else if (item.machine_condition == iss_pkg::COND_UNKNOWN) begin
                  ctx_in.cd_active = 1'b0;
                  ctx_in.st        = iss_pkg::ST_MONITOR;
                  lat = lat & ~(iss_pkg::L_RELAY | iss_pkg::L_RED | iss_pkg::L_GREEN);
                  lat = lat | iss_pkg::L_YELLOW;
               end else if (expired) begin
                  ctx_in.st = iss_pkg::ST_REQ;
               end
            end
            iss_pkg::ST_REQ: begin
               if (item.machine_condition == iss_pkg::COND_IDLE &&
                   item.link_health == iss_pkg::LINK_OK) begin
                  lat = lat | iss_pkg::L_RELAY | iss_pkg::L_PINA;
                  lat = lat & ~(iss_pkg::L_RED | iss_pkg::L_GREEN | iss_pkg::L_PINB);
                  ctx_in.relay_on = item.now_ms;
                  ctx_in.st       = iss_pkg::ST_ACTIVE;
                  event_hit       = 1'b1;
               end else begin
                  ctx_in.cd_active = 1'b0;
                  ctx_in.st        = iss_pkg::ST_MONITOR;
               end
            end
            iss_pkg::ST_ACTIVE: begin
               if (hold_done) begin
                  lat = lat & ~iss_pkg::L_RELAY;
                  ctx_in.st = iss_pkg::ST_MONITOR;
               end
            end
            iss_pkg::ST_FAULT: begin
               ctx_in.cd_active = 1'b0;
               lat = lat & ~(iss_pkg::L_RELAY | iss_pkg::L_RED | iss_pkg::L_GREEN);
               lat = lat | iss_pkg::L_YELLOW;
               ctx_in.st = iss_pkg::ST_MONITOR;
            end
            default: begin
               ctx_in.cd_active = 1'b0;
               ctx_in.st        = iss_pkg::ST_FAULT;
            end
         endcase
      end
      ctx_in.latches      = lat;
      res.latches         = lat;
      res.state_code      = iss_pkg::state_code_of(ctx_in.st);
      res.idle_stop_event = event_hit;
   end

endmodule

// ----- rtl/iss_checker.sv -----
// ----------------------------------------------------------------------------
// iss_checker
// port-level checks of the idle stop supervisor, bound to the top level
// ----------------------------------------------------------------------------
`include "idle_stop_supervisor_core_assert.svh"

module iss_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [iss_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [2:0] code;
   logic       relay;
   logic       stop_event;
   logic       code_ok;

   assign code       = rsp_tdata[2:0];
   assign relay      = rsp_tdata[3];
   assign stop_event = rsp_tdata[9];
   assign code_ok    = code <= iss_pkg::CODE_FAULT;

   `ISS_ASSERT_IMP(a_code_range, clock, reset, rsp_tvalid, code_ok, "state code out of range")
   `ISS_ASSERT_IMP(a_event_relay, clock, reset, rsp_tvalid && stop_event,
      relay && (code == iss_pkg::CODE_ACTIVE), "stop event without active relay")
   `ISS_ASSERT_NXT_ANY(a_reset_quiet, clock, reset, !rsp_tvalid, "result valid after reset")
   `ISS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule

bind idle_stop_supervisor_core iss_checker u_iss_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/tb_idle_stop_supervisor_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_idle_stop_supervisor_core
// self-checking bench for the idle stop supervisor core: supervision ticks go
// in on the req stream, and every status transaction on the rsp stream is
// compared with a cycle-free model of the state machine, its countdown and
// its output latches; several register settings and idle patterns are used
// ----------------------------------------------------------------------------
module tb_idle_stop_supervisor_core;

   localparam logic [1:0] COND_OTHER = 2'd3;
   localparam int         PHASE_ITEMS = 75;
   localparam int         RSP_HOLD_CYCLES = 200;

   class status_scoreboard;
      logic [iss_pkg::TIMEOUT_W-1:0] idle_timeout;
      logic [iss_pkg::WARN_W-1:0]    warn_window;
      logic [iss_pkg::HOLD_W-1:0]    relay_hold;
      logic [2:0]                    mode;
      logic                          cd_active;
      logic [iss_pkg::TIME_W-1:0]    cd_start;
      logic [iss_pkg::TIME_W-1:0]    relay_on;
      logic [5:0]                    latches;
      iss_pkg::result_type           expected_status[$];
      int                            errors;

      function new();
         idle_timeout = iss_pkg::TIMEOUT_RST;
         warn_window  = iss_pkg::WARN_RST;
         relay_hold   = iss_pkg::HOLD_RST;
         mode         = iss_pkg::CODE_MONITOR;
         cd_active    = 1'b0;
         cd_start     = '0;
         relay_on     = '0;
         latches      = '0;
         errors       = 0;
      endfunction

      function void set_register(logic [iss_pkg::CSR_ADDR_W-1:0] addr,
                                 logic [iss_pkg::CSR_W-1:0] value);
         case (addr)
            iss_pkg::CSR_IDLE_TIMEOUT: idle_timeout = value[iss_pkg::TIMEOUT_W-1:0];
            iss_pkg::CSR_WARN_WINDOW:  warn_window  = value[iss_pkg::WARN_W-1:0];
            iss_pkg::CSR_RELAY_HOLD:   relay_hold   = value[iss_pkg::HOLD_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_status.size();
      endfunction

      function void note_tick(iss_pkg::item_type it);
         logic [iss_pkg::TIME_W-1:0] elapsed;
         logic [iss_pkg::TIME_W-1:0] remaining;
         logic                       expired;
         logic                       evt;
         iss_pkg::result_type        res;
         evt = 1'b0;
         if (it.link_health == iss_pkg::LINK_CAN_ERROR ||
             it.link_health == iss_pkg::LINK_CAN_TMO) begin
            cd_active = 1'b0;
            mode = iss_pkg::CODE_FAULT;
            latches |= iss_pkg::L_YELLOW;
            latches &= ~iss_pkg::L_GREEN;
         end else begin
            case (mode)
               iss_pkg::CODE_MONITOR: begin
                  if (it.machine_condition == iss_pkg::COND_WORKING) begin
                     cd_active = 1'b0;
                     latches |= (iss_pkg::L_PINA | iss_pkg::L_PINB | iss_pkg::L_GREEN);
                     latches &= ~(iss_pkg::L_RELAY | iss_pkg::L_YELLOW | iss_pkg::L_RED);
                  end else if (it.machine_condition == iss_pkg::COND_IDLE &&
                               it.work_done) begin
                     mode = iss_pkg::CODE_IDLE;
                  end
               end
               iss_pkg::CODE_IDLE: begin
                  cd_active = 1'b1;
                  cd_start = it.now_ms;
                  mode = iss_pkg::CODE_COUNT;
                  latches &= ~(iss_pkg::L_RELAY | iss_pkg::L_GREEN | iss_pkg::L_PINA);
                  latches |= iss_pkg::L_PINB;
               end
               iss_pkg::CODE_COUNT: begin
                  elapsed = cd_active ? it.now_ms - cd_start : '0;
                  remaining = (elapsed >= idle_timeout) ? '0 : idle_timeout - elapsed;
                  expired = cd_active && (elapsed >= idle_timeout);
                  if (remaining <= warn_window) begin
                     latches |= (iss_pkg::L_RED | iss_pkg::L_PINA);
                     latches &= ~(iss_pkg::L_YELLOW | iss_pkg::L_GREEN);
                  end else begin
                     latches &= ~iss_pkg::L_RED;
                     latches |= iss_pkg::L_PINB;
                  end
                  if (it.machine_condition == iss_pkg::COND_WORKING) begin
                     cd_active = 1'b0;
                     mode = iss_pkg::CODE_MONITOR;
                     latches &= ~(iss_pkg::L_RELAY | iss_pkg::L_YELLOW |
                                  iss_pkg::L_RED | iss_pkg::L_GREEN);
                  end else if (it.machine_condition == iss_pkg::COND_UNKNOWN) begin
                     cd_active = 1'b0;
                     latches &= ~(iss_pkg::L_RELAY | iss_pkg::L_RED | iss_pkg::L_GREEN);
                     latches |= iss_pkg::L_YELLOW;
                     mode = iss_pkg::CODE_MONITOR;
                  end else if (expired) begin
                     mode = iss_pkg::CODE_REQ;
                  end
               end
               iss_pkg::CODE_REQ: begin
                  if (it.machine_condition == iss_pkg::COND_IDLE &&
                      it.link_health == iss_pkg::LINK_OK) begin
                     latches |= (iss_pkg::L_RELAY | iss_pkg::L_PINA);
                     latches &= ~(iss_pkg::L_RED | iss_pkg::L_GREEN | iss_pkg::L_PINB);
                     relay_on = it.now_ms;
                     mode = iss_pkg::CODE_ACTIVE;
                     evt = 1'b1;
                  end else begin
                     cd_active = 1'b0;
                     mode = iss_pkg::CODE_MONITOR;
                  end
               end
               iss_pkg::CODE_ACTIVE: begin
                  if (iss_pkg::TIME_W'(it.now_ms - relay_on) >=
                      iss_pkg::TIME_W'(relay_hold)) begin
                     latches &= ~iss_pkg::L_RELAY;
                     mode = iss_pkg::CODE_MONITOR;
                  end
               end
               iss_pkg::CODE_FAULT: begin
                  cd_active = 1'b0;
                  latches &= ~(iss_pkg::L_RELAY | iss_pkg::L_RED | iss_pkg::L_GREEN);
                  latches |= iss_pkg::L_YELLOW;
                  mode = iss_pkg::CODE_MONITOR;
               end
               default: begin
                  cd_active = 1'b0;
                  mode = iss_pkg::CODE_FAULT;
               end
            endcase
         end
         res.state_code = mode;
         res.latches = latches;
         res.idle_stop_event = evt;
         expected_status.push_back(res);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_status(logic [iss_pkg::RSP_DATA_W-1:0] data);
         string               latch_name[6];
         iss_pkg::result_type got;
         iss_pkg::result_type want;
         latch_name = '{"cutoff_relay", "lamp_yellow", "lamp_red",
                        "lamp_green", "aux_pin_a", "aux_pin_b"};
         got = data[$bits(iss_pkg::result_type)-1:0];
         if (expected_status.size() == 0) begin
            $display("%0t: unexpected status transaction, expected none, actual %h",
                     $time, data);
            errors++;
            return;
         end
         want = expected_status.pop_front();
         compare_field("state_code", want.state_code, got.state_code);
         for (int b = 0; b < 6; b++) begin
            compare_field(latch_name[b], want.latches[b], got.latches[b]);
         end
         compare_field("idle_stop_event", want.idle_stop_event, got.idle_stop_event);
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [iss_pkg::REQ_DATA_W-1:0]   req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [iss_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             csr_we = 1'b0;
   logic [iss_pkg::CSR_ADDR_W-1:0]   csr_addr = '0;
   logic [iss_pkg::CSR_W-1:0]        csr_wdata = '0;

   int                               req_idle_pct = 0;
   int                               rsp_idle_pct = 0;
   logic                             rsp_hold_toggle = 1'b0;
   status_scoreboard                 status_board = new();

   idle_stop_supervisor_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random stalls plus an occasional long hold-off
   initial begin
      logic hold_seen;
      int   hold_left;
      hold_seen = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_toggle != hold_seen) begin
            hold_seen = rsp_hold_toggle;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // transaction monitor
   initial begin
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_tvalid && rsp_tready) begin
               status_board.check_status(rsp_tdata);
            end
            if (req_tvalid && req_tready) begin
               status_board.note_tick(
                  iss_pkg::item_type'(req_tdata[$bits(iss_pkg::item_type)-1:0]));
            end
         end
      end
   end

   task automatic send_tick(iss_pkg::item_type it);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= iss_pkg::REQ_DATA_W'(it);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drive_tick(logic [iss_pkg::TIME_W-1:0] now, logic [1:0] health,
                             logic [1:0] cond, logic worked);
      iss_pkg::item_type it;
      it.now_ms = now;
      it.link_health = health;
      it.machine_condition = cond;
      it.work_done = worked;
      send_tick(it);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (status_board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [iss_pkg::CSR_ADDR_W-1:0] addr,
                            logic [iss_pkg::CSR_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      status_board.set_register(addr, value);
   endtask

   initial begin : stimulus
      int unsigned                phase_timeout[6];
      int unsigned                phase_warn[6];
      int unsigned                phase_hold[6];
      logic [iss_pkg::TIME_W-1:0] t0;
      logic [iss_pkg::TIME_W-1:0] now_cur;
      logic [iss_pkg::TIME_W-1:0] span;
      int unsigned                pick;
      iss_pkg::item_type          it;

      phase_timeout = '{100, 0, 16777215, 1000, 50, 0};
      phase_warn    = '{30, 0, 65535, 65535, 0, 0};
      phase_hold    = '{50, 0, 65535, 0, 65535, 0};
      phase_timeout[5] = $urandom_range(5000);
      phase_warn[5]    = $urandom_range(3000);
      phase_hold[5]    = $urandom_range(2000);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed ticks under the register defaults
      t0 = 32'hFFFF_8000;
      drive_tick(32'd0, iss_pkg::LINK_OK, iss_pkg::COND_WORKING, 1'b0);
      drive_tick(32'd10, iss_pkg::LINK_OK, COND_OTHER, 1'b1);
      drive_tick(32'd20, iss_pkg::LINK_OK, iss_pkg::COND_IDLE, 1'b0);
      drive_tick(32'd30, iss_pkg::LINK_OTHER, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(t0, iss_pkg::LINK_OK, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(t0 + 32'd10, iss_pkg::LINK_OK, COND_OTHER, 1'b1);
      drive_tick(t0 + 32'd56000, iss_pkg::LINK_OK, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(t0 + 32'd60000, iss_pkg::LINK_OK, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(t0 + 32'd60010, iss_pkg::LINK_OK, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(t0 + 32'd60500, iss_pkg::LINK_OK, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(t0 + 32'd60810, iss_pkg::LINK_OK, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(32'd40, iss_pkg::LINK_CAN_ERROR, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(32'd50, iss_pkg::LINK_CAN_TMO, iss_pkg::COND_WORKING, 1'b0);
      drive_tick(32'hFFFF_FFFF, iss_pkg::LINK_OK, iss_pkg::COND_WORKING, 1'b1);
      drive_tick(32'd100, iss_pkg::LINK_OK, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(32'd200, iss_pkg::LINK_OK, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(32'd70200, iss_pkg::LINK_OK, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(32'd70300, iss_pkg::LINK_OTHER, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(32'd71000, iss_pkg::LINK_OK, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(32'd71100, iss_pkg::LINK_OK, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(32'd71200, iss_pkg::LINK_OK, iss_pkg::COND_UNKNOWN, 1'b1);
      drive_tick(32'd72000, iss_pkg::LINK_OK, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(32'd72100, iss_pkg::LINK_OK, iss_pkg::COND_IDLE, 1'b1);
      drive_tick(32'd72200, iss_pkg::LINK_OK, iss_pkg::COND_WORKING, 1'b1);
      wait_drained();

      now_cur = $urandom;
      for (int p = 0; p < 6; p++) begin
         write_csr(iss_pkg::CSR_IDLE_TIMEOUT, iss_pkg::CSR_W'(phase_timeout[p]));
         write_csr(iss_pkg::CSR_WARN_WINDOW, iss_pkg::CSR_W'(phase_warn[p]));
         write_csr(iss_pkg::CSR_RELAY_HOLD, iss_pkg::CSR_W'(phase_hold[p]));
         csr_we <= 1'b0;
         if (p < 2) begin
            req_idle_pct = 17;
            rsp_idle_pct = 88;
         end else if (p < 4) begin
            req_idle_pct = 88;
            rsp_idle_pct = 17;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         span = ((phase_timeout[p] > phase_hold[p]) ? phase_timeout[p] : phase_hold[p]) + 1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == 25) rsp_hold_toggle <= ~rsp_hold_toggle;
            if (i == 50) wait_drained();
            if ($urandom_range(99) < 15) begin
               it = iss_pkg::item_type'($urandom_range(1) ? {$urandom, $urandom}
                                                          : {32'd0, $urandom});
               it.now_ms = $urandom;
            end else begin
               pick = $urandom_range(99);
               if (pick < 40) now_cur += $urandom_range(span / 8);
               else if (pick < 85) now_cur += $urandom_range(span + span / 2, span / 2);
               else now_cur += $urandom;
               it.now_ms = now_cur;
               pick = $urandom_range(99);
               it.link_health = (pick < 85) ? iss_pkg::LINK_OK :
                                (pick < 90) ? iss_pkg::LINK_CAN_ERROR :
                                (pick < 95) ? iss_pkg::LINK_CAN_TMO : iss_pkg::LINK_OTHER;
               pick = $urandom_range(99);
               it.machine_condition = (pick < 70) ? iss_pkg::COND_IDLE :
                                      (pick < 80) ? iss_pkg::COND_WORKING :
                                      (pick < 90) ? iss_pkg::COND_UNKNOWN : COND_OTHER;
               it.work_done = ($urandom_range(99) < 85);
            end
            send_tick(it);
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (status_board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/iss_pkg.sv
rtl/iss_step.sv
rtl/idle_stop_supervisor_core.sv
rtl/iss_checker.sv
tb/tb_idle_stop_supervisor_core.sv
